// File: hw/rtl/hws_pkg.sv
// Shared types and constants for the host watchdog supervisor.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package hws_pkg;

  // Field widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned DelayW   = 32;
  localparam int unsigned LongW    = 18;
  localparam int unsigned ShortW   = 24;
  localparam int unsigned NewbootW = 11;
  localparam int unsigned WarnW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Opcodes
  localparam logic [OpW-1:0] OP_TICK    = 3'd0;
  localparam logic [OpW-1:0] OP_ALIVE   = 3'd1;
  localparam logic [OpW-1:0] OP_NEWBOOT = 3'd2;
  localparam logic [OpW-1:0] OP_OLDBOOT = 3'd3;
  localparam logic [OpW-1:0] OP_ONESHOT = 3'd4;
  localparam logic [OpW-1:0] OP_STATUS  = 3'd5;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_LONG_LIMIT    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SHORT_LIMIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_NEWBOOT_LIMIT = 2'd2;

  // Limits and defaults, in seconds
  localparam logic [LongW-1:0]    LONG_MIN_SECS        = LongW'(60 * 40);
  localparam logic [LongW-1:0]    LONG_MAX_SECS        = LongW'(60 * 60 * 72);
  localparam logic [LongW-1:0]    LONG_DEFAULT_SECS    = LongW'(60 * 60 * 6);
  localparam logic [ShortW-1:0]   SHORT_MIN_SECS       = ShortW'(60 * 15);
  localparam logic [NewbootW-1:0] NEWBOOT_DEFAULT_SECS = NewbootW'(60 * 10);
  localparam logic [NewbootW-1:0] NEWBOOT_MIN_SECS     = NewbootW'(60 * 2);
  localparam logic [NewbootW-1:0] NEWBOOT_MAX_SECS     = NewbootW'(60 * 30);
  localparam logic [WarnW-1:0]    WARNING_SECS         = WarnW'(10);

  // Limit registers as seen by the core
  typedef struct packed {
    logic [LongW-1:0]    long_period;
    logic [ShortW-1:0]   short_period;
    logic [NewbootW-1:0] newboot_window;
  } limits_t;

  // One result item
  typedef struct packed {
    logic                boot_normal;
    logic                warning_on;
    logic                reset_pulse;
    logic                long_expired;
    logic                short_expired;
    logic                oneshot_expired;
    logic                newboot_expired;
    logic                alternate_flag;
    logic [LongW-1:0]    long_count_now;
    logic [ShortW-1:0]   short_count_now;
    logic [NewbootW-1:0] newboot_count_now;
    logic [DelayW-1:0]   oneshot_count_now;
  } result_t;

endpackage

// File: hw/rtl/hws_cfg.sv
// Limit register file: an out-of-range write stores the register's default instead.
// Depends on hws_pkg.
`timescale 1ns / 1ps

module hws_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [hws_pkg::CfgIdxW-1:0]    wr_index,
  input  logic [hws_pkg::CfgDataW-1:0]   wr_data,
  output hws_pkg::limits_t               limits
);

  hws_pkg::limits_t limits_r, limits_nxt;

  logic [hws_pkg::LongW-1:0]    long_wr;
  logic [hws_pkg::ShortW-1:0]   short_wr;
  logic [hws_pkg::NewbootW-1:0] newboot_wr;

  // Check the write data of each register against its legal range
  always_comb begin
    long_wr    = wr_data[hws_pkg::LongW-1:0];
    short_wr   = wr_data[hws_pkg::ShortW-1:0];
    newboot_wr = wr_data[hws_pkg::NewbootW-1:0];
    if (long_wr < hws_pkg::LONG_MIN_SECS || long_wr > hws_pkg::LONG_MAX_SECS) begin
      long_wr = hws_pkg::LONG_DEFAULT_SECS;
    end
    if (short_wr != '0 && short_wr < hws_pkg::SHORT_MIN_SECS) begin
      short_wr = '0;
    end
    if (newboot_wr < hws_pkg::NEWBOOT_MIN_SECS ||
        newboot_wr > hws_pkg::NEWBOOT_MAX_SECS) begin
      newboot_wr = hws_pkg::NEWBOOT_DEFAULT_SECS;
    end
  end

  // Select the register; drop writes beyond the list
  always_comb begin
    limits_nxt = limits_r;
    if (wr_en) begin
      case (wr_index)
        hws_pkg::REG_LONG_LIMIT:    limits_nxt.long_period    = long_wr;
        hws_pkg::REG_SHORT_LIMIT:   limits_nxt.short_period   = short_wr;
        hws_pkg::REG_NEWBOOT_LIMIT: limits_nxt.newboot_window = newboot_wr;
        default:                    limits_nxt = limits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.long_period    <= hws_pkg::LONG_DEFAULT_SECS;
      limits_r.short_period   <= '0;
      limits_r.newboot_window <= hws_pkg::NEWBOOT_DEFAULT_SECS;
    end else begin
      limits_r <= limits_nxt;
    end
  end

  assign limits = limits_r;

endmodule

// File: hw/rtl/hws_core.sv
// Supervisor state and the single-pass update for one request.
// Depends on hws_pkg; limits come from hws_cfg.
`timescale 1ns / 1ps

module hws_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic [hws_pkg::OpW-1:0]      opcode,
  input  logic [hws_pkg::DelayW-1:0]   oneshot_delay,
  input  hws_pkg::limits_t             limits,
  output hws_pkg::result_t             result
);

  logic [hws_pkg::LongW-1:0]    long_r, long_nxt;
  logic [hws_pkg::ShortW-1:0]   short_r, short_nxt;
  logic [hws_pkg::NewbootW-1:0] newboot_r, newboot_nxt;
  logic [hws_pkg::DelayW-1:0]   oneshot_r, oneshot_nxt;
  logic [hws_pkg::WarnW-1:0]    warn_r, warn_nxt;
  logic                         alt_r, alt_nxt;
  logic                         boot_r, boot_nxt;
  logic                         warn_on_r, warn_on_nxt;

  logic [hws_pkg::LongW:0]  long_sum;
  logic [hws_pkg::ShortW:0] short_sum;
  logic hit_long, hit_short, hit_newboot, hit_oneshot, hit_warn;

  // Watchdog increments, one bit wider for the limit compare
  assign long_sum  = {1'b0, long_r} + 1'b1;
  assign short_sum = {1'b0, short_r} + 1'b1;

  always_comb begin
    long_nxt    = long_r;
    short_nxt   = short_r;
    newboot_nxt = newboot_r;
    oneshot_nxt = oneshot_r;
    warn_nxt    = warn_r;
    alt_nxt     = alt_r;
    boot_nxt    = boot_r;
    warn_on_nxt = warn_on_r;
    hit_long    = 1'b0;
    hit_short   = 1'b0;
    hit_newboot = 1'b0;
    hit_oneshot = 1'b0;
    hit_warn    = 1'b0;

    case (opcode)
      hws_pkg::OP_TICK: begin
        // Advance the watchdogs; wrap at the limit, a zero limit holds
        if (limits.long_period != '0) begin
          hit_long = long_sum >= {1'b0, limits.long_period};
          long_nxt = hit_long ? '0 : long_sum[hws_pkg::LongW-1:0];
        end
        if (limits.short_period != '0) begin
          hit_short = short_sum >= {1'b0, limits.short_period};
          short_nxt = hit_short ? '0 : short_sum[hws_pkg::ShortW-1:0];
        end
        // Advance the countdowns; a hit when one reaches zero
        if (newboot_r != '0) begin
          newboot_nxt = newboot_r - 1'b1;
          hit_newboot = newboot_r == hws_pkg::NewbootW'(1);
        end
        if (oneshot_r != '0) begin
          oneshot_nxt = oneshot_r - 1'b1;
          hit_oneshot = oneshot_r == hws_pkg::DelayW'(1);
        end
        if (warn_r != '0) begin
          warn_nxt = warn_r - 1'b1;
          hit_warn = warn_r == hws_pkg::WarnW'(1);
        end
        // Handle the hits in order
        if (hit_long) begin
          if (alt_r) begin
            boot_nxt    = 1'b1;
            newboot_nxt = limits.newboot_window;
          end
          alt_nxt = ~alt_r;
        end
        if (hit_long || hit_short || hit_oneshot) begin
          warn_on_nxt = 1'b1;
          warn_nxt    = hws_pkg::WARNING_SECS;
        end
        if (hit_newboot) begin
          boot_nxt = 1'b0;
        end
        if (hit_warn) begin
          warn_on_nxt = 1'b0;
        end
      end
      hws_pkg::OP_ALIVE: begin
        long_nxt  = '0;
        short_nxt = '0;
        alt_nxt   = 1'b0;
      end
      hws_pkg::OP_NEWBOOT: begin
        boot_nxt    = 1'b1;
        newboot_nxt = limits.newboot_window;
      end
      hws_pkg::OP_OLDBOOT: begin
        boot_nxt    = 1'b0;
        newboot_nxt = '0;
      end
      hws_pkg::OP_ONESHOT: begin
        oneshot_nxt = oneshot_delay;
      end
      default: begin
        // Status and unused codes only report
      end
    endcase
  end

  // Commit the state only when a request is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r    <= '0;
      short_r   <= '0;
      newboot_r <= '0;
      oneshot_r <= '0;
      warn_r    <= '0;
      alt_r     <= 1'b0;
      boot_r    <= 1'b0;
      warn_on_r <= 1'b0;
    end else if (step_en) begin
      long_r    <= long_nxt;
      short_r   <= short_nxt;
      newboot_r <= newboot_nxt;
      oneshot_r <= oneshot_nxt;
      warn_r    <= warn_nxt;
      alt_r     <= alt_nxt;
      boot_r    <= boot_nxt;
      warn_on_r <= warn_on_nxt;
    end
  end

  // Report the state after the step
  always_comb begin
    result.boot_normal       = boot_nxt;
    result.warning_on        = warn_on_nxt;
    result.reset_pulse       = hit_warn;
    result.long_expired      = hit_long;
    result.short_expired     = hit_short;
    result.oneshot_expired   = hit_oneshot;
    result.newboot_expired   = hit_newboot;
    result.alternate_flag    = alt_nxt;
    result.long_count_now    = long_nxt;
    result.short_count_now   = short_nxt;
    result.newboot_count_now = newboot_nxt;
    result.oneshot_count_now = oneshot_nxt;
  end

endmodule

// File: hw/rtl/host_watchdog_supervisor_unit.sv
// Top level of the host watchdog supervisor: input register, limit registers, core, result register.
// Depends on hws_pkg, hws_cfg and hws_core.
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_ready    opcode, oneshot_delay
//   out_     result     out_valid / out_ready  status flags and counts
//   cfg_     write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted request is held in the input register, is processed by the core when
// the result register is free or draining, and then lands in the result register.
// One request per cycle is sustained while out_ready is high; the state update is combinational.
// A stalled result holds the input stage only when it is also full.
// Reset is synchronous, active low; cfg_ready is always high.
`timescale 1ns / 1ps

module host_watchdog_supervisor_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hws_pkg::OpW-1:0]             in_opcode,
  input  logic [hws_pkg::DelayW-1:0]          in_oneshot_delay,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_boot_normal,
  output logic                                out_warning_on,
  output logic                                out_reset_pulse,
  output logic                                out_long_expired,
  output logic                                out_short_expired,
  output logic                                out_oneshot_expired,
  output logic                                out_newboot_expired,
  output logic                                out_alternate_flag,
  output logic [hws_pkg::LongW-1:0]           out_long_count_now,
  output logic [hws_pkg::ShortW-1:0]          out_short_count_now,
  output logic [hws_pkg::NewbootW-1:0]        out_newboot_count_now,
  output logic [hws_pkg::DelayW-1:0]          out_oneshot_count_now,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hws_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [hws_pkg::CfgDataW-1:0]        cfg_data
);

  logic                          in_v_r, in_v_nxt;
  logic [hws_pkg::OpW-1:0]       in_op_r, in_op_nxt;
  logic [hws_pkg::DelayW-1:0]    in_delay_r, in_delay_nxt;
  logic                          out_v_r, out_v_nxt;
  hws_pkg::result_t              out_res_r, out_res_nxt;

  hws_pkg::limits_t              limits;
  hws_pkg::result_t              step_res;
  logic                          advance;
  logic                          in_accept;

  assign cfg_ready = 1'b1;

  hws_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  hws_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (advance),
    .opcode        (in_op_r),
    .oneshot_delay (in_delay_r),
    .limits        (limits),
    .result        (step_res)
  );

  // Process the held request when the result register is free or draining
  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    in_v_nxt     = in_accept ? 1'b1 : (advance ? 1'b0 : in_v_r);
    in_op_nxt    = in_accept ? in_opcode : in_op_r;
    in_delay_nxt = in_accept ? in_oneshot_delay : in_delay_r;
    out_v_nxt    = advance ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
    out_res_nxt  = advance ? step_res : out_res_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_op_r    <= in_op_nxt;
    in_delay_r <= in_delay_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_valid             = out_v_r;
  assign out_boot_normal       = out_res_r.boot_normal;
  assign out_warning_on        = out_res_r.warning_on;
  assign out_reset_pulse       = out_res_r.reset_pulse;
  assign out_long_expired      = out_res_r.long_expired;
  assign out_short_expired     = out_res_r.short_expired;
  assign out_oneshot_expired   = out_res_r.oneshot_expired;
  assign out_newboot_expired   = out_res_r.newboot_expired;
  assign out_alternate_flag    = out_res_r.alternate_flag;
  assign out_long_count_now    = out_res_r.long_count_now;
  assign out_short_count_now   = out_res_r.short_count_now;
  assign out_newboot_count_now = out_res_r.newboot_count_now;
  assign out_oneshot_count_now = out_res_r.oneshot_count_now;

endmodule
